>>> rtl/core/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types, constants and helpers for the periodic task table scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int TICK_WIDTH = 16;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   // payload widths fixed by the interface
   localparam int OPCODE_W  = 2;
   localparam int MS_W      = 20;
   localparam int TARGET_W  = 8;
   localparam int KIND_W    = 3;
   localparam int TSLOT_W   = 3;
   localparam int PENDING_W = 8;

   // ms / 10 as (ms * ceil(2^23 / 10)) >> 23, exact for every 20-bit ms
   localparam int                RECIP_W   = 20;
   localparam logic [RECIP_W-1:0] RECIP_10 = 20'hCCCCD;
   localparam int                PROD_W    = MS_W + RECIP_W;
   localparam int                QUO_SHIFT = 23;
   localparam int                QUO_W     = PROD_W - QUO_SHIFT;
   localparam int                CMP_W     = (QUO_W > TICK_WIDTH) ? QUO_W : TICK_WIDTH;

   typedef logic [TICK_WIDTH-1:0] tick_type;
   typedef logic [PENDING_W-1:0]  pending_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [PROD_W-1:0]     prod_type;

   localparam tick_type          TICK_MAX     = {TICK_WIDTH{1'b1}};
   localparam logic [CMP_W-1:0]  TICK_MAX_EXT = CMP_W'(TICK_MAX);
   localparam pending_type       PENDING_MAX  = {PENDING_W{1'b1}};

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DISP = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_DEL  = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] K_ADDED   = 3'd0;
   localparam logic [KIND_W-1:0] K_FULL    = 3'd1;
   localparam logic [KIND_W-1:0] K_TICK    = 3'd2;
   localparam logic [KIND_W-1:0] K_RUN     = 3'd3;
   localparam logic [KIND_W-1:0] K_NONE    = 3'd4;
   localparam logic [KIND_W-1:0] K_DELETED = 3'd5;
   localparam logic [KIND_W-1:0] K_BAD     = 3'd6;

   // where the slot number of a result word comes from
   localparam logic [1:0] SRC_ZERO   = 2'd0;
   localparam logic [1:0] SRC_IDX    = 2'd1;
   localparam logic [1:0] SRC_FREE   = 2'd2;
   localparam logic [1:0] SRC_TARGET = 2'd3;

   typedef struct packed {
      logic              lat_en;
      logic              mul_en;
      logic              mul_period;
      logic              dq_en;
      logic              add_wr;
      logic              tick_en;
      logic              disp_en;
      logic              del_en;
      logic              out_en;
      logic [KIND_W-1:0] out_kind;
      logic [1:0]        out_src;
      logic              out_last;
      slot_type          idx;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic target_ok;
      logic due_here;
      logic due_above;
   } status_type;

   function automatic tick_type sat_ticks(input logic [QUO_W-1:0] q);
      logic [CMP_W-1:0] qe;
      qe = CMP_W'(q);
      if (qe > TICK_MAX_EXT) begin
         return TICK_MAX;
      end
      return tick_type'(qe);
   endfunction

endpackage

>>> rtl/core/ptts_datapath.sv
// ----------------------------------------------------------------------------
// ptts_datapath
// Slot table, shared reciprocal multiplier for ms-to-tick conversion,
// per-slot tick/dispatch update and the result word register.
// ----------------------------------------------------------------------------
module ptts_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ptts_pkg::cmd_type                  cmd,
   output ptts_pkg::status_type               status,
   input  logic [ptts_pkg::MS_W-1:0]          req_delay_ms,
   input  logic [ptts_pkg::MS_W-1:0]          req_period_ms,
   input  logic [ptts_pkg::TARGET_W-1:0]      req_target_slot,
   output logic [ptts_pkg::KIND_W-1:0]        rsp_result_kind,
   output logic [ptts_pkg::TSLOT_W-1:0]       rsp_task_slot,
   output logic                               rsp_last_result
);

   logic [ptts_pkg::MS_W-1:0]     delay_ms_ff;
   logic [ptts_pkg::MS_W-1:0]     period_ms_ff;
   logic [ptts_pkg::TARGET_W-1:0] target_ff;
   ptts_pkg::prod_type            prod_ff;
   ptts_pkg::prod_type            prod_in;
   ptts_pkg::tick_type            dq_ff;
   ptts_pkg::tick_type            pq;

   logic [ptts_pkg::TASK_SLOTS-1:0] valid_ff, valid_in;
   ptts_pkg::tick_type    delay_ff   [ptts_pkg::TASK_SLOTS];
   ptts_pkg::tick_type    delay_in   [ptts_pkg::TASK_SLOTS];
   ptts_pkg::tick_type    period_ff  [ptts_pkg::TASK_SLOTS];
   ptts_pkg::tick_type    period_in  [ptts_pkg::TASK_SLOTS];
   ptts_pkg::pending_type pending_ff [ptts_pkg::TASK_SLOTS];
   ptts_pkg::pending_type pending_in [ptts_pkg::TASK_SLOTS];

   logic [ptts_pkg::TASK_SLOTS-1:0] due;
   ptts_pkg::slot_type free_idx;
   ptts_pkg::slot_type tgt_idx;
   logic               full;
   logic               due_above;

   logic [ptts_pkg::KIND_W-1:0]  kind_ff;
   logic [ptts_pkg::TSLOT_W-1:0] tslot_ff, tslot_in;
   logic                         last_ff;

   assign tgt_idx = target_ff[ptts_pkg::SLOT_W-1:0];
   assign pq      = ptts_pkg::sat_ticks(prod_ff[ptts_pkg::PROD_W-1:ptts_pkg::QUO_SHIFT]);

   // one multiplier, used for delay then period
   always_comb begin
      prod_in = (cmd.mul_period ? ptts_pkg::PROD_W'(period_ms_ff) : ptts_pkg::PROD_W'(delay_ms_ff))
                * ptts_pkg::PROD_W'(ptts_pkg::RECIP_10);
   end

   // lowest free slot
   always_comb begin
      free_idx = '0;
      full     = 1'b1;
      for (int s = ptts_pkg::TASK_SLOTS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_idx = ptts_pkg::slot_type'(s);
            full     = 1'b0;
         end
      end
   end

   always_comb begin
      due_above = 1'b0;
      for (int s = 0; s < ptts_pkg::TASK_SLOTS; s++) begin
         due[s] = valid_ff[s] && (pending_ff[s] != '0);
         if (ptts_pkg::slot_type'(s) > cmd.idx && due[s]) begin
            due_above = 1'b1;
         end
      end
   end

   assign status.full      = full;
   assign status.target_ok = target_ff < ptts_pkg::TARGET_W'(ptts_pkg::TASK_SLOTS);
   assign status.due_here  = due[cmd.idx];
   assign status.due_above = due_above;

   always_comb begin
      valid_in   = valid_ff;
      delay_in   = delay_ff;
      period_in  = period_ff;
      pending_in = pending_ff;
      if (cmd.add_wr) begin
         valid_in[free_idx]   = 1'b1;
         delay_in[free_idx]   = dq_ff;
         period_in[free_idx]  = pq;
         pending_in[free_idx] = '0;
      end
      if (cmd.tick_en && valid_ff[cmd.idx]) begin
         if (delay_ff[cmd.idx] != '0) begin
            delay_in[cmd.idx] = delay_ff[cmd.idx] - ptts_pkg::tick_type'(1);
         end else begin
            delay_in[cmd.idx] = period_ff[cmd.idx];
            if (pending_ff[cmd.idx] != ptts_pkg::PENDING_MAX) begin
               pending_in[cmd.idx] = pending_ff[cmd.idx] + ptts_pkg::pending_type'(1);
            end
         end
      end
      if (cmd.disp_en) begin
         pending_in[cmd.idx] = pending_ff[cmd.idx] - ptts_pkg::pending_type'(1);
         // one-shot task leaves the table once run
         if (period_ff[cmd.idx] == '0) begin
            valid_in[cmd.idx] = 1'b0;
         end
      end
      if (cmd.del_en) begin
         valid_in[tgt_idx] = 1'b0;
      end
   end

   always_comb begin
      case (cmd.out_src)
         ptts_pkg::SRC_IDX:    tslot_in = ptts_pkg::TSLOT_W'(cmd.idx);
         ptts_pkg::SRC_FREE:   tslot_in = ptts_pkg::TSLOT_W'(free_idx);
         ptts_pkg::SRC_TARGET: tslot_in = ptts_pkg::TSLOT_W'(tgt_idx);
         default:              tslot_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff   <= delay_in;
      period_ff  <= period_in;
      pending_ff <= pending_in;
      if (cmd.lat_en) begin
         delay_ms_ff  <= req_delay_ms;
         period_ms_ff <= req_period_ms;
         target_ff    <= req_target_slot;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.dq_en) begin
         dq_ff <= pq;
      end
      if (cmd.out_en) begin
         kind_ff  <= cmd.out_kind;
         tslot_ff <= tslot_in;
         last_ff  <= cmd.out_last;
      end
   end

   assign rsp_result_kind = kind_ff;
   assign rsp_task_slot   = tslot_ff;
   assign rsp_last_result = last_ff;

endmodule

>>> rtl/core/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// ptts_ctrl
// Request sequencer: conversion steps for add, one-slot-per-cycle scan for
// tick and dispatch (stalled by a full output), and the result valid flag.
// ----------------------------------------------------------------------------
module ptts_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ptts_pkg::OPCODE_W-1:0] req_opcode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ptts_pkg::cmd_type             cmd,
   input  ptts_pkg::status_type          status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ADD_D = 3'd1;
   localparam logic [2:0] S_ADD_P = 3'd2;
   localparam logic [2:0] S_ADD_W = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_DEL   = 3'd5;

   localparam ptts_pkg::slot_type LAST_IDX = ptts_pkg::slot_type'(ptts_pkg::TASK_SLOTS - 1);

   logic [2:0]                    state_ff, state_in;
   logic [ptts_pkg::OPCODE_W-1:0] op_ff, op_in;
   ptts_pkg::slot_type            idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          can_emit;
   logic                          is_end;

   // a new word may be loaded when the output register is empty or draining
   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign is_end   = idx_ff == LAST_IDX;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.idx   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.lat_en = 1'b1;
               op_in      = req_opcode;
               idx_in     = '0;
               unique case (req_opcode) inside
                  ptts_pkg::OP_ADD:                   state_in = S_ADD_D;
                  ptts_pkg::OP_TICK, ptts_pkg::OP_DISP: state_in = S_SCAN;
                  default:                            state_in = S_DEL;
               endcase
            end
         end
         S_ADD_D: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ADD_P;
         end
         S_ADD_P: begin
            cmd.dq_en      = 1'b1;
            cmd.mul_en     = 1'b1;
            cmd.mul_period = 1'b1;
            state_in       = S_ADD_W;
         end
         S_ADD_W: begin
            if (can_emit) begin
               cmd.out_en   = 1'b1;
               cmd.out_last = 1'b1;
               if (status.full) begin
                  cmd.out_kind = ptts_pkg::K_FULL;
                  cmd.out_src  = ptts_pkg::SRC_ZERO;
               end else begin
                  cmd.add_wr   = 1'b1;
                  cmd.out_kind = ptts_pkg::K_ADDED;
                  cmd.out_src  = ptts_pkg::SRC_FREE;
               end
               state_in = S_IDLE;
            end
         end
         S_DEL: begin
            if (can_emit) begin
               cmd.out_en   = 1'b1;
               cmd.out_last = 1'b1;
               if (status.target_ok) begin
                  cmd.del_en   = 1'b1;
                  cmd.out_kind = ptts_pkg::K_DELETED;
                  cmd.out_src  = ptts_pkg::SRC_TARGET;
               end else begin
                  cmd.out_kind = ptts_pkg::K_BAD;
                  cmd.out_src  = ptts_pkg::SRC_ZERO;
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (op_ff == ptts_pkg::OP_TICK) begin
               if (!is_end) begin
                  cmd.tick_en = 1'b1;
                  idx_in      = idx_ff + ptts_pkg::slot_type'(1);
               end else if (can_emit) begin
                  cmd.tick_en  = 1'b1;
                  cmd.out_en   = 1'b1;
                  cmd.out_kind = ptts_pkg::K_TICK;
                  cmd.out_src  = ptts_pkg::SRC_ZERO;
                  cmd.out_last = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (status.due_here) begin
               if (can_emit) begin
                  cmd.disp_en  = 1'b1;
                  cmd.out_en   = 1'b1;
                  cmd.out_kind = ptts_pkg::K_RUN;
                  cmd.out_src  = ptts_pkg::SRC_IDX;
                  cmd.out_last = !status.due_above;
                  // nothing due further up: this run is the final word
                  if (!status.due_above) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = idx_ff + ptts_pkg::slot_type'(1);
                  end
               end
            end else if (!is_end) begin
               idx_in = idx_ff + ptts_pkg::slot_type'(1);
            end else if (can_emit) begin
               // reached the top with no run emitted
               cmd.out_en   = 1'b1;
               cmd.out_kind = ptts_pkg::K_NONE;
               cmd.out_src  = ptts_pkg::SRC_ZERO;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= ptts_pkg::OP_ADD;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/periodic_task_table_scheduler.sv
// Add: two passes of the shared ms-to-tick multiplier before the result word is loaded.
// Tick: one slot per cycle through the table; only the last slot waits on output stalls.
// Dispatch: one run word per due slot (a none word if none is due), held by output stalls.
// One request in flight; the next is taken once the last word is loaded in the output register.
// Synchronous active-high reset frees every slot at once and empties the output register.
// ----------------------------------------------------------------------------
// periodic_task_table_scheduler
// Time-triggered cooperative task table: add, tick, dispatch and delete.
// ----------------------------------------------------------------------------
module periodic_task_table_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ptts_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ptts_pkg::MS_W-1:0]     req_delay_ms,
   input  logic [ptts_pkg::MS_W-1:0]     req_period_ms,
   input  logic [ptts_pkg::TARGET_W-1:0] req_target_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ptts_pkg::KIND_W-1:0]   rsp_result_kind,
   output logic [ptts_pkg::TSLOT_W-1:0]  rsp_task_slot,
   output logic                          rsp_last_result
);

   ptts_pkg::cmd_type    cmd;
   ptts_pkg::status_type status;

   ptts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   ptts_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_delay_ms    (req_delay_ms),
      .req_period_ms   (req_period_ms),
      .req_target_slot (req_target_slot),
      .rsp_result_kind (rsp_result_kind),
      .rsp_task_slot   (rsp_task_slot),
      .rsp_last_result (rsp_last_result)
   );

endmodule
